@@ sv/pbwf_pkg.sv @@
package pbwf_pkg;

   localparam int LEN_BITS_DEFAULT    = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VALUE,
      PH_LEN,
      PH_FIXED,
      PH_PAYLOAD,
      PH_SKIP
   } phase_type;

   localparam logic [2:0] KIND_VARINT  = 3'd0;
   localparam logic [2:0] KIND_FIXED32 = 3'd1;
   localparam logic [2:0] KIND_LEN_HDR = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_LEN     = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_TAG         = 3'd1;
   localparam logic [2:0] ERR_VALUE       = 3'd2;
   localparam logic [2:0] ERR_LEN_VARINT  = 3'd3;
   localparam logic [2:0] ERR_LEN_OVERRUN = 3'd4;
   localparam logic [2:0] ERR_FIXED32     = 3'd5;
   localparam logic [2:0] ERR_BAD_TYPE    = 3'd6;

   localparam logic [2:0]  VARINT_LAST_IDX = 3'd4;
   localparam logic [1:0]  FIXED_LAST_IDX  = 2'd3;
   localparam logic [15:0] FIXED_MIN_AFTER = 16'd4;

   typedef struct packed {
      logic        has_main;
      logic [2:0]  kind;
      logic [28:0] field_num;
      logic [2:0]  wire_type;
      logic [31:0] value;
      logic        has_end;
      logic [2:0]  end_error;
   } cmd_type;

endpackage

@@ sv/protobuf_wire_field_parser_unit.sv @@
// channel   direction  handshake            payload
// req       in         push / full          req_data_byte, req_bytes_left
// rsp       out        pop / empty          rsp_kind, rsp_field_num, rsp_wire_type,
//                                           rsp_value, rsp_error_code, rsp_last
// One byte accepted per cycle while full is low; a word passes through the command queue into the result register.
// A byte that yields a field result and the end marker holds the result register for two words.
// The command queue (QUEUE_DEPTH words) absorbs those two-word bytes and result stalls.
// full rises only when the queue is full. Synchronous reset, no clearing pass.
module protobuf_wire_field_parser_unit #(
   parameter int LEN_BITS    = pbwf_pkg::LEN_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = pbwf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_bytes_left,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [28:0] rsp_field_num,
   output logic [2:0]  rsp_wire_type,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   logic              q_full, q_empty, q_push, q_pop;
   pbwf_pkg::cmd_type q_wdata, q_rdata;

   assign full = q_full;

   pbwf_front #(
      .LEN_BITS (LEN_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (push && !q_full),
      .data_byte  (req_data_byte),
      .bytes_left (req_bytes_left),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   pbwf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   pbwf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_rdata),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .kind       (rsp_kind),
      .field_num  (rsp_field_num),
      .wire_type  (rsp_wire_type),
      .value      (rsp_value),
      .error_code (rsp_error_code),
      .last       (rsp_last)
   );

endmodule

@@ sv/pbwf_front.sv @@
module pbwf_front #(
   parameter int LEN_BITS = pbwf_pkg::LEN_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic [15:0]       bytes_left,
   output logic              q_push,
   output pbwf_pkg::cmd_type q_data
);

   pbwf_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         acc_ff, acc_in;
   logic [2:0]          vcnt_ff, vcnt_in;
   logic [28:0]         field_ff, field_in;
   logic [LEN_BITS-1:0] pay_ff, pay_in;
   logic [1:0]          fcnt_ff, fcnt_in;
   logic [2:0]          err_ff, err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pbwf_pkg::PH_TAG;
         acc_ff   <= '0;
         vcnt_ff  <= '0;
         field_ff <= '0;
         pay_ff   <= '0;
         fcnt_ff  <= '0;
         err_ff   <= pbwf_pkg::ERR_NONE;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         vcnt_ff  <= vcnt_in;
         field_ff <= field_in;
         pay_ff   <= pay_in;
         fcnt_ff  <= fcnt_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      logic                last_byte;
      logic [15:0]         after;
      logic [31:0]         vadd;
      logic [31:0]         fadd;
      logic [LEN_BITS-1:0] pay_dec;
      logic [2:0]          end_err;

      last_byte = (bytes_left <= 16'd1);
      after     = last_byte ? 16'd0 : bytes_left - 16'd1;
      vadd      = acc_ff | (32'(data_byte[6:0]) << (5'(vcnt_ff) * 5'd7));
      fadd      = acc_ff | (32'(data_byte) << {fcnt_ff, 3'b000});
      pay_dec   = (pay_ff != '0) ? pay_ff - LEN_BITS'(1) : pay_ff;
      end_err   = pbwf_pkg::ERR_NONE;

      phase_in = phase_ff;
      acc_in   = acc_ff;
      vcnt_in  = vcnt_ff;
      field_in = field_ff;
      pay_in   = pay_ff;
      fcnt_in  = fcnt_ff;
      err_in   = err_ff;
      q_data   = '0;

      if (accept) begin
         case (phase_ff)
            pbwf_pkg::PH_TAG: begin
               acc_in = vadd;
               if (!data_byte[7]) begin
                  field_in = vadd[31:3];
                  acc_in   = '0;
                  vcnt_in  = '0;
                  case (vadd[2:0])
                     pbwf_pkg::WT_VARINT: phase_in = pbwf_pkg::PH_VALUE;
                     pbwf_pkg::WT_LEN:    phase_in = pbwf_pkg::PH_LEN;
                     pbwf_pkg::WT_FIXED32: begin
                        if (after < pbwf_pkg::FIXED_MIN_AFTER) begin
                           err_in   = pbwf_pkg::ERR_FIXED32;
                           phase_in = pbwf_pkg::PH_SKIP;
                        end else begin
                           phase_in = pbwf_pkg::PH_FIXED;
                           fcnt_in  = '0;
                        end
                     end
                     default: begin
                        err_in   = pbwf_pkg::ERR_BAD_TYPE;
                        phase_in = pbwf_pkg::PH_SKIP;
                     end
                  endcase
               end else if (vcnt_ff >= pbwf_pkg::VARINT_LAST_IDX) begin
                  err_in   = pbwf_pkg::ERR_TAG;
                  phase_in = pbwf_pkg::PH_SKIP;
               end else begin
                  vcnt_in = vcnt_ff + 3'd1;
               end
            end
            pbwf_pkg::PH_VALUE: begin
               acc_in = vadd;
               if (!data_byte[7]) begin
                  q_data.has_main  = 1'b1;
                  q_data.kind      = pbwf_pkg::KIND_VARINT;
                  q_data.field_num = field_ff;
                  q_data.wire_type = pbwf_pkg::WT_VARINT;
                  q_data.value     = vadd;
                  acc_in   = '0;
                  vcnt_in  = '0;
                  phase_in = pbwf_pkg::PH_TAG;
               end else if (vcnt_ff >= pbwf_pkg::VARINT_LAST_IDX) begin
                  err_in   = pbwf_pkg::ERR_VALUE;
                  phase_in = pbwf_pkg::PH_SKIP;
               end else begin
                  vcnt_in = vcnt_ff + 3'd1;
               end
            end
            pbwf_pkg::PH_LEN: begin
               acc_in = vadd;
               if (!data_byte[7]) begin
                  acc_in  = '0;
                  vcnt_in = '0;
                  if (vadd > 32'(after) || (vadd >> LEN_BITS) != 32'd0) begin
                     err_in   = pbwf_pkg::ERR_LEN_OVERRUN;
                     phase_in = pbwf_pkg::PH_SKIP;
                  end else begin
                     q_data.has_main  = 1'b1;
                     q_data.kind      = pbwf_pkg::KIND_LEN_HDR;
                     q_data.field_num = field_ff;
                     q_data.wire_type = pbwf_pkg::WT_LEN;
                     q_data.value     = vadd;
                     pay_in   = LEN_BITS'(vadd);
                     phase_in = (vadd == 32'd0) ? pbwf_pkg::PH_TAG : pbwf_pkg::PH_PAYLOAD;
                  end
               end else if (vcnt_ff >= pbwf_pkg::VARINT_LAST_IDX) begin
                  err_in   = pbwf_pkg::ERR_LEN_VARINT;
                  phase_in = pbwf_pkg::PH_SKIP;
               end else begin
                  vcnt_in = vcnt_ff + 3'd1;
               end
            end
            pbwf_pkg::PH_FIXED: begin
               if (fcnt_ff >= pbwf_pkg::FIXED_LAST_IDX) begin
                  q_data.has_main  = 1'b1;
                  q_data.kind      = pbwf_pkg::KIND_FIXED32;
                  q_data.field_num = field_ff;
                  q_data.wire_type = pbwf_pkg::WT_FIXED32;
                  q_data.value     = fadd;
                  acc_in   = '0;
                  fcnt_in  = '0;
                  phase_in = pbwf_pkg::PH_TAG;
               end else begin
                  acc_in  = fadd;
                  fcnt_in = fcnt_ff + 2'd1;
               end
            end
            pbwf_pkg::PH_PAYLOAD: begin
               q_data.has_main  = 1'b1;
               q_data.kind      = pbwf_pkg::KIND_PAYLOAD;
               q_data.field_num = field_ff;
               q_data.wire_type = pbwf_pkg::WT_LEN;
               q_data.value     = 32'(data_byte);
               pay_in = pay_dec;
               if (pay_dec == '0) begin
                  phase_in = pbwf_pkg::PH_TAG;
               end
            end
            default: begin
            end
         endcase

         if (last_byte) begin
            end_err = err_in;
            if (err_in == pbwf_pkg::ERR_NONE) begin
               if (phase_in == pbwf_pkg::PH_TAG && vcnt_in != 3'd0) begin
                  end_err = pbwf_pkg::ERR_TAG;
               end else if (phase_in == pbwf_pkg::PH_VALUE) begin
                  end_err = pbwf_pkg::ERR_VALUE;
               end else if (phase_in == pbwf_pkg::PH_LEN) begin
                  end_err = pbwf_pkg::ERR_LEN_VARINT;
               end else if (phase_in == pbwf_pkg::PH_PAYLOAD) begin
                  end_err = pbwf_pkg::ERR_LEN_OVERRUN;
               end else if (phase_in == pbwf_pkg::PH_FIXED) begin
                  end_err = pbwf_pkg::ERR_FIXED32;
               end
            end
            q_data.has_end   = 1'b1;
            q_data.end_error = end_err;
            phase_in = pbwf_pkg::PH_TAG;
            acc_in   = '0;
            vcnt_in  = '0;
            field_in = '0;
            pay_in   = '0;
            fcnt_in  = '0;
            err_in   = pbwf_pkg::ERR_NONE;
         end
      end

      q_push = accept && (q_data.has_main || q_data.has_end);
   end

   assert property (@(posedge clock) disable iff (reset)
      (err_ff != pbwf_pkg::ERR_NONE) |-> (phase_ff == pbwf_pkg::PH_SKIP))
      else $error("error code held outside skip phase");

   assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= pbwf_pkg::VARINT_LAST_IDX)
      else $error("varint byte count beyond five bytes");

   assert property (@(posedge clock) disable iff (reset)
      (accept && bytes_left <= 16'd1) |=>
         (phase_ff == pbwf_pkg::PH_TAG && err_ff == pbwf_pkg::ERR_NONE))
      else $error("parser not cleared after last byte");

endmodule

@@ sv/pbwf_queue.sv @@
module pbwf_queue #(
   parameter int DEPTH = pbwf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pbwf_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output pbwf_pkg::cmd_type pop_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pbwf_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

@@ sv/pbwf_back.sv @@
module pbwf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  pbwf_pkg::cmd_type q_data,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output logic [2:0]        kind,
   output logic [28:0]       field_num,
   output logic [2:0]        wire_type,
   output logic [31:0]       value,
   output logic [2:0]        error_code,
   output logic              last
);

   logic        valid_ff, valid_in;
   logic        pend_ff, pend_in;
   logic [2:0]  pend_err_ff, pend_err_in;
   logic [2:0]  kind_ff, kind_in;
   logic [28:0] fid_ff, fid_in;
   logic [2:0]  wt_ff, wt_in;
   logic [31:0] value_ff, value_in;
   logic [2:0]  err_ff, err_in;
   logic        last_ff, last_in;

   always_comb begin
      logic free;
      free = !valid_ff || pop;

      valid_in    = valid_ff;
      pend_in     = pend_ff;
      pend_err_in = pend_err_ff;
      kind_in     = kind_ff;
      fid_in      = fid_ff;
      wt_in       = wt_ff;
      value_in    = value_ff;
      err_in      = err_ff;
      last_in     = last_ff;
      q_pop       = 1'b0;

      if (free) begin
         valid_in = 1'b0;
         if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
            kind_in  = pbwf_pkg::KIND_END;
            fid_in   = '0;
            wt_in    = '0;
            value_in = '0;
            err_in   = pend_err_ff;
            last_in  = 1'b1;
         end else if (!q_empty) begin
            valid_in = 1'b1;
            q_pop    = 1'b1;
            if (q_data.has_main) begin
               kind_in     = q_data.kind;
               fid_in      = q_data.field_num;
               wt_in       = q_data.wire_type;
               value_in    = q_data.value;
               err_in      = pbwf_pkg::ERR_NONE;
               last_in     = 1'b0;
               pend_in     = q_data.has_end;
               pend_err_in = q_data.end_error;
            end else begin
               kind_in  = pbwf_pkg::KIND_END;
               fid_in   = '0;
               wt_in    = '0;
               value_in = '0;
               err_in   = q_data.end_error;
               last_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_err_ff <= pend_err_in;
      kind_ff     <= kind_in;
      fid_ff      <= fid_in;
      wt_ff       <= wt_in;
      value_ff    <= value_in;
      err_ff      <= err_in;
      last_ff     <= last_in;
   end

   assign empty      = !valid_ff;
   assign kind       = kind_ff;
   assign field_num  = fid_ff;
   assign wire_type  = wt_ff;
   assign value      = value_ff;
   assign error_code = err_ff;
   assign last       = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> valid_ff)
      else $error("end marker pending without a field result on show");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (kind_ff == pbwf_pkg::KIND_END))
      else $error("last flag on a result that is not an end marker");

endmodule

@@ bench/protobuf_wire_field_parser_unit_tb.sv @@
module protobuf_wire_field_parser_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  kind;
      logic [28:0] field_num;
      logic [2:0]  wire_type;
      logic [31:0] value;
      logic [2:0]  error_code;
      logic        last;
   } field_word_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_data_byte;
   logic [15:0] req_bytes_left;
   logic        empty;
   logic        pop;
   logic [2:0]  rsp_kind;
   logic [28:0] rsp_field_num;
   logic [2:0]  rsp_wire_type;
   logic [31:0] rsp_value;
   logic [2:0]  rsp_error_code;
   logic        rsp_last;

   protobuf_wire_field_parser_unit uut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data_byte  (req_data_byte),
      .req_bytes_left (req_bytes_left),
      .empty          (empty),
      .pop            (pop),
      .rsp_kind       (rsp_kind),
      .rsp_field_num  (rsp_field_num),
      .rsp_wire_type  (rsp_wire_type),
      .rsp_value      (rsp_value),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   // parser state mirror
   pbwf_pkg::phase_type ph;
   logic [31:0] acc;
   logic [2:0]  vcnt;
   logic [28:0] cur_fid;
   logic [15:0] pay_left;
   logic [1:0]  fcnt;
   logic [2:0]  err_latch;

   field_word_type expected_words[$];
   logic [7:0]  msg_bytes[$];
   logic [15:0] msg_left[$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int items_sent;
   int messages_sent;
   int words_checked;
   int mismatch_count;
   int full_stalls;
   int end_markers;
   int error_ends;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("[protobuf_wire_field_parser_unit] ERROR");
      $finish;
   end

   function automatic void clear_parser();
      ph        = pbwf_pkg::PH_TAG;
      acc       = '0;
      vcnt      = '0;
      cur_fid   = '0;
      pay_left  = '0;
      fcnt      = '0;
      err_latch = pbwf_pkg::ERR_NONE;
   endfunction

   function automatic void expect_word(logic [2:0] kind, logic [28:0] fid, logic [2:0] wt,
                                       logic [31:0] val, logic [2:0] err, logic lst);
      field_word_type w;
      w.kind       = kind;
      w.field_num  = fid;
      w.wire_type  = wt;
      w.value      = val;
      w.error_code = err;
      w.last       = lst;
      expected_words.push_back(w);
   endfunction

   function automatic void trip(logic [2:0] code);
      err_latch = code;
      ph        = pbwf_pkg::PH_SKIP;
   endfunction

   function automatic int absorb_varint(logic [7:0] b);
      acc = acc | (32'(b[6:0]) << (7 * vcnt));
      if (!b[7]) begin
         return 1;
      end
      if (vcnt >= pbwf_pkg::VARINT_LAST_IDX) begin
         return -1;
      end
      vcnt = vcnt + 3'd1;
      return 0;
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic [15:0] bl);
      logic        at_end;
      logic [15:0] after;
      logic [2:0]  wt;
      logic [31:0] len;
      longint      len_max;
      int          r;
      at_end  = (bl <= 16'd1);
      after   = at_end ? 16'd0 : bl - 16'd1;
      len_max = (longint'(1) << pbwf_pkg::LEN_BITS_DEFAULT) - 1;
      case (ph)
         pbwf_pkg::PH_TAG: begin
            r = absorb_varint(b);
            if (r < 0) begin
               trip(pbwf_pkg::ERR_TAG);
            end else if (r > 0) begin
               wt      = acc[2:0];
               cur_fid = acc[31:3];
               acc     = '0;
               vcnt    = '0;
               if (wt == pbwf_pkg::WT_VARINT) begin
                  ph = pbwf_pkg::PH_VALUE;
               end else if (wt == pbwf_pkg::WT_LEN) begin
                  ph = pbwf_pkg::PH_LEN;
               end else if (wt == pbwf_pkg::WT_FIXED32) begin
                  if (after < pbwf_pkg::FIXED_MIN_AFTER) begin
                     trip(pbwf_pkg::ERR_FIXED32);
                  end else begin
                     ph   = pbwf_pkg::PH_FIXED;
                     fcnt = '0;
                  end
               end else begin
                  trip(pbwf_pkg::ERR_BAD_TYPE);
               end
            end
         end
         pbwf_pkg::PH_VALUE: begin
            r = absorb_varint(b);
            if (r < 0) begin
               trip(pbwf_pkg::ERR_VALUE);
            end else if (r > 0) begin
               expect_word(pbwf_pkg::KIND_VARINT, cur_fid, pbwf_pkg::WT_VARINT, acc,
                           pbwf_pkg::ERR_NONE, 1'b0);
               acc  = '0;
               vcnt = '0;
               ph   = pbwf_pkg::PH_TAG;
            end
         end
         pbwf_pkg::PH_LEN: begin
            r = absorb_varint(b);
            if (r < 0) begin
               trip(pbwf_pkg::ERR_LEN_VARINT);
            end else if (r > 0) begin
               len  = acc;
               acc  = '0;
               vcnt = '0;
               if (len > 32'(after) || longint'(len) > len_max) begin
                  trip(pbwf_pkg::ERR_LEN_OVERRUN);
               end else begin
                  expect_word(pbwf_pkg::KIND_LEN_HDR, cur_fid, pbwf_pkg::WT_LEN, len,
                              pbwf_pkg::ERR_NONE, 1'b0);
                  pay_left = len[15:0];
                  ph       = (len == 0) ? pbwf_pkg::PH_TAG : pbwf_pkg::PH_PAYLOAD;
               end
            end
         end
         pbwf_pkg::PH_FIXED: begin
            acc = acc | (32'(b) << (8 * fcnt));
            if (fcnt >= pbwf_pkg::FIXED_LAST_IDX) begin
               expect_word(pbwf_pkg::KIND_FIXED32, cur_fid, pbwf_pkg::WT_FIXED32, acc,
                           pbwf_pkg::ERR_NONE, 1'b0);
               acc  = '0;
               fcnt = '0;
               ph   = pbwf_pkg::PH_TAG;
            end else begin
               fcnt = fcnt + 2'd1;
            end
         end
         pbwf_pkg::PH_PAYLOAD: begin
            expect_word(pbwf_pkg::KIND_PAYLOAD, cur_fid, pbwf_pkg::WT_LEN, 32'(b),
                        pbwf_pkg::ERR_NONE, 1'b0);
            if (pay_left > 0) begin
               pay_left = pay_left - 16'd1;
            end
            if (pay_left == 0) begin
               ph = pbwf_pkg::PH_TAG;
            end
         end
         default: begin
         end
      endcase
      if (at_end) begin
         if (err_latch == pbwf_pkg::ERR_NONE) begin
            if (ph == pbwf_pkg::PH_TAG && vcnt > 0) begin
               err_latch = pbwf_pkg::ERR_TAG;
            end else if (ph == pbwf_pkg::PH_VALUE) begin
               err_latch = pbwf_pkg::ERR_VALUE;
            end else if (ph == pbwf_pkg::PH_LEN) begin
               err_latch = pbwf_pkg::ERR_LEN_VARINT;
            end else if (ph == pbwf_pkg::PH_PAYLOAD) begin
               err_latch = pbwf_pkg::ERR_LEN_OVERRUN;
            end else if (ph == pbwf_pkg::PH_FIXED) begin
               err_latch = pbwf_pkg::ERR_FIXED32;
            end
         end
         expect_word(pbwf_pkg::KIND_END, '0, '0, '0, err_latch, 1'b1);
         end_markers++;
         if (err_latch != pbwf_pkg::ERR_NONE) begin
            error_ends++;
         end
         clear_parser();
      end
   endfunction

   function automatic void report_mismatch(string what, field_word_type exp_w,
                                           field_word_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s at %0t: expected kind %0d fid %0h wt %0d value %h err %0d last %0b",
                  what, $realtime, exp_w.kind, exp_w.field_num, exp_w.wire_type,
                  exp_w.value, exp_w.error_code, exp_w.last);
         $display("   actual kind %0d fid %0h wt %0d value %h err %0d last %0b",
                  got.kind, got.field_num, got.wire_type, got.value, got.error_code,
                  got.last);
      end
   endfunction

   function automatic void check_word();
      field_word_type got;
      field_word_type exp_w;
      got.kind       = rsp_kind;
      got.field_num  = rsp_field_num;
      got.wire_type  = rsp_wire_type;
      got.value      = rsp_value;
      got.error_code = rsp_error_code;
      got.last       = rsp_last;
      if (expected_words.size() == 0) begin
         report_mismatch("unexpected word", '0, got);
      end else begin
         exp_w = expected_words.pop_front();
         if (got.kind !== exp_w.kind || got.field_num !== exp_w.field_num ||
             got.wire_type !== exp_w.wire_type || got.value !== exp_w.value ||
             got.error_code !== exp_w.error_code || got.last !== exp_w.last) begin
            report_mismatch("word mismatch", exp_w, got);
         end else begin
            words_checked++;
         end
      end
   endfunction

   initial begin
      pop       = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
         end
         @(posedge clock);
         if (!reset && pop && !empty) begin
            check_word();
         end
      end
   end

   task automatic send_item(logic [7:0] b, logic [15:0] bl);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push           <= 1'b1;
      req_data_byte  <= b;
      req_bytes_left <= bl;
      @(posedge clock);
      while (full) begin
         full_stalls++;
         @(posedge clock);
      end
      parse_byte(b, bl);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message();
      int i;
      for (i = 0; i < msg_bytes.size(); i++) begin
         send_item(msg_bytes[i], msg_left[i]);
      end
      messages_sent++;
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      do begin
         @(negedge clock);
      end while (expected_words.size() != 0);
   endtask

   function automatic logic [31:0] tag_of(logic [28:0] fid, logic [2:0] wt);
      return {fid, wt};
   endfunction

   function automatic void add_varint(logic [31:0] v, int pad, bit dirty);
      int groups;
      int total;
      int k;
      logic [7:0] b;
      groups = 1;
      for (k = 1; k < 5; k++) begin
         if ((v >> (7 * k)) != 0) begin
            groups = k + 1;
         end
      end
      total = groups + pad;
      if (total > 5) begin
         total = 5;
      end
      for (k = 0; k < total; k++) begin
         b = 8'((v >> (7 * k)) & 32'h7F);
         if (k < total - 1) begin
            b[7] = 1'b1;
         end
         if (k == 4 && dirty) begin
            b[6:4] = 3'($urandom_range(7));
         end
         msg_bytes.push_back(b);
      end
   endfunction

   function automatic void add_long_varint();
      repeat (5) begin
         msg_bytes.push_back(8'h80 | 8'($urandom_range(127)));
      end
      msg_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void count_down(int offset, bit end_zero);
      int n;
      int i;
      n = msg_bytes.size();
      msg_left.delete();
      for (i = 0; i < n - 1; i++) begin
         msg_left.push_back(16'(n - i + offset));
      end
      msg_left.push_back(end_zero ? 16'd0 : 16'd1);
   endfunction

   function automatic logic [28:0] pick_field_num();
      case ($urandom_range(9))
         6: return 29'($urandom_range(2047, 16));
         7: return 29'($urandom);
         8: return 29'h1FFF_FFFF;
         9: return '0;
         default: return 29'($urandom_range(15, 1));
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(127));
         default: return $urandom;
      endcase
   endfunction

   // returns 1 when the message must end after this field
   function automatic bit add_field();
      logic [28:0] fid;
      logic [2:0]  wt;
      int          sel;
      int          pad;
      int          len;
      bit          dirty;
      fid   = pick_field_num();
      pad   = ($urandom_range(7) == 0) ? $urandom_range(4, 1) : 0;
      dirty = $urandom_range(1);
      sel   = $urandom_range(99);
      if (sel < 32) begin
         add_varint(tag_of(fid, pbwf_pkg::WT_VARINT), pad, dirty);
         add_varint(pick_value(), ($urandom_range(5) == 0) ? 4 : 0, dirty);
      end else if (sel < 52) begin
         add_varint(tag_of(fid, pbwf_pkg::WT_FIXED32), pad, dirty);
         repeat (4) msg_bytes.push_back(8'($urandom_range(255)));
      end else if (sel < 86) begin
         len = $urandom_range(5);
         add_varint(tag_of(fid, pbwf_pkg::WT_LEN), pad, dirty);
         add_varint(32'(len), ($urandom_range(7) == 0) ? 2 : 0, 1'b0);
         repeat (len) msg_bytes.push_back(8'($urandom_range(255)));
      end else if (sel < 89) begin
         do begin
            wt = 3'($urandom_range(7));
         end while (wt == pbwf_pkg::WT_VARINT || wt == pbwf_pkg::WT_LEN ||
                    wt == pbwf_pkg::WT_FIXED32);
         add_varint(tag_of(fid, wt), pad, dirty);
      end else if (sel < 92) begin
         case ($urandom_range(2))
            0: begin
            end
            1: add_varint(tag_of(fid, pbwf_pkg::WT_VARINT), 0, 1'b0);
            default: add_varint(tag_of(fid, pbwf_pkg::WT_LEN), 0, 1'b0);
         endcase
         add_long_varint();
      end else if (sel < 96) begin
         add_varint(tag_of(fid, pbwf_pkg::WT_LEN), 0, 1'b0);
         if ($urandom_range(1) == 0) begin
            add_varint($urandom_range(32'hFFFF_FFFF, 32'h1_0000), 0, 1'b0);
         end else begin
            add_varint($urandom_range(65535, 100), 0, 1'b0);
         end
         msg_bytes.push_back(8'($urandom_range(255)));
      end else begin
         add_varint(tag_of(fid, pbwf_pkg::WT_FIXED32), pad, dirty);
         repeat ($urandom_range(3)) msg_bytes.push_back(8'($urandom_range(255)));
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void build_message();
      int n;
      int i;
      int offset;
      bit stop;
      msg_bytes.delete();
      msg_left.delete();
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(6, 1);
         for (i = 0; i < n; i++) begin
            msg_bytes.push_back(8'($urandom_range(255)));
            msg_left.push_back((i == n - 1) ? 16'($urandom_range(1))
                                             : 16'($urandom_range(65535, 2)));
         end
         return;
      end
      n    = $urandom_range(4, 1);
      stop = 1'b0;
      for (i = 0; i < n && !stop; i++) begin
         stop = add_field();
      end
      if ($urandom_range(11) == 0 && msg_bytes.size() > 1) begin
         repeat ($urandom_range(msg_bytes.size() - 1, 1)) void'(msg_bytes.pop_back());
      end
      offset = ($urandom_range(15) == 0) ? $urandom_range(65000, 1) : 0;
      count_down(offset, $urandom_range(9) == 0);
   endfunction

   task automatic test_directed_cases();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // varint result and end marker from one byte
      msg_bytes = '{};
      add_varint(tag_of(29'd1, pbwf_pkg::WT_VARINT), 0, 1'b0);
      msg_bytes.push_back(8'h00);
      count_down(0, 1'b0);
      send_message();
      // widest field number, all-ones fixed32
      msg_bytes = '{};
      add_varint(tag_of(29'h1FFF_FFFF, pbwf_pkg::WT_FIXED32), 0, 1'b0);
      repeat (4) msg_bytes.push_back(8'hFF);
      count_down(0, 1'b0);
      send_message();
      // payload byte, then an empty length field on the last byte
      msg_bytes = '{};
      add_varint(tag_of(29'd2, pbwf_pkg::WT_LEN), 0, 1'b0);
      msg_bytes.push_back(8'h01);
      msg_bytes.push_back(8'h80);
      add_varint(tag_of(29'd3, pbwf_pkg::WT_LEN), 0, 1'b0);
      msg_bytes.push_back(8'h00);
      count_down(0, 1'b0);
      send_message();
      // bad wire type
      msg_bytes = '{};
      add_varint(tag_of(29'd1, 3'd7), 0, 1'b0);
      count_down(0, 1'b0);
      send_message();
      // over-long tag varint
      msg_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
      count_down(0, 1'b0);
      send_message();
      // length past the end of the message, closed by zero bytes left
      msg_bytes = '{};
      add_varint(tag_of(29'd1, pbwf_pkg::WT_LEN), 0, 1'b0);
      add_varint(32'hFFFF, 0, 1'b0);
      msg_bytes.push_back(8'h55);
      count_down(65530, 1'b1);
      send_message();
      // fixed32 with too few bytes behind it
      msg_bytes = '{};
      add_varint(tag_of(29'd1, pbwf_pkg::WT_FIXED32), 0, 1'b0);
      msg_bytes.push_back(8'h00);
      msg_bytes.push_back(8'h00);
      count_down(0, 1'b0);
      send_message();
      wait_drained();
   endtask

   task automatic test_message_stream(int idle_pct, int stall_pct, int n_items);
      int start;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start          = items_sent;
      while (items_sent - start < n_items) begin
         build_message();
         send_message();
      end
   endtask

   task automatic test_result_hold_off();
      int start;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 300;
      start          = items_sent;
      while (items_sent - start < 60) begin
         build_message();
         send_message();
      end
      wait_drained();
   endtask

   task automatic test_drain_pause();
      send_idle_pct  = 20;
      recv_stall_pct = 30;
      repeat (4) begin
         build_message();
         send_message();
         wait_drained();
      end
   endtask

   initial begin
      reset          = 1'b1;
      push           = 1'b0;
      req_data_byte  = '0;
      req_bytes_left = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      messages_sent  = 0;
      words_checked  = 0;
      mismatch_count = 0;
      full_stalls    = 0;
      end_markers    = 0;
      error_ends     = 0;
      clear_parser();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_message_stream(0, 0, 270);
      test_message_stream(54, 0, 270);
      test_message_stream(0, 54, 270);
      test_message_stream(34, 34, 270);
      test_result_hold_off();
      test_drain_pause();

      wait_drained();
      repeat (10) @(negedge clock);
      if (expected_words.size() != 0) begin
         mismatch_count++;
         $display("%0d expected words never arrived", expected_words.size());
      end
      $display("%0d bytes in %0d messages, %0d words matched, %0d end markers (%0d with error)",
               items_sent, messages_sent, words_checked, end_markers, error_ends);
      $display("%0d cycles with input held off by full, %0d mismatches",
               full_stalls, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[protobuf_wire_field_parser_unit] OK");
      end else begin
         $display("[protobuf_wire_field_parser_unit] ERROR");
      end
      $finish;
   end

endmodule
